// ===== hw/rtl/sse_pkg.sv =====
// Shared constants and types for the sum-of-subsets search block.
`timescale 1ns / 1ps

package sse_pkg;

    localparam int MAX_ITEMS_DEF   = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int TARGET_W   = 20;
    localparam int COUNT_W    = 5;
    localparam int INDEX_W    = 4;
    localparam int WEIGHT_W   = 16;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                func;
        logic [INDEX_W-1:0]  index;
        logic [WEIGHT_W-1:0] weight;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [MASK_W-1:0] mask;
        logic              exhausted;
    } resp_t;

endpackage

// ===== hw/rtl/sse_core.sv =====
// Search engine: weight store, level stack and the shared step sequencer.
`timescale 1ns / 1ps

module sse_core #(
    parameter int MAX_ITEMS   = sse_pkg::MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = sse_pkg::WEIGHT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_clear,
    input  logic [sse_pkg::TARGET_W-1:0] target_sum,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] active_count,
    input  sse_pkg::req_t                req,
    output logic                         ready,
    output sse_pkg::resp_t               resp,
    input  logic                         resp_ack
);

    localparam int LVL_W  = $clog2(MAX_ITEMS + 1);
    localparam int AW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int BASE_W = (WEIGHT_BITS > sse_pkg::TARGET_W) ? WEIGHT_BITS : sse_pkg::TARGET_W;
    localparam int SUM_W  = BASE_W + LVL_W + 1;
    localparam int WIDE_W = (MAX_ITEMS > sse_pkg::MASK_W) ? MAX_ITEMS : sse_pkg::MASK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOTAL,
        S_READ,
        S_ADD,
        S_EVAL,
        S_POP,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_INCL,
        ST_EXCL,
        ST_POP
    } stage_t;

    typedef struct packed {
        stage_t           stage;
        logic [SUM_W-1:0] psum;
        logic [SUM_W-1:0] rsum;
    } lvl_t;

    logic [WEIGHT_BITS-1:0] wmem [MAX_ITEMS];
    lvl_t                   lmem [MAX_ITEMS];

    logic [WEIGHT_BITS-1:0] rd0_reg;
    logic [WEIGHT_BITS-1:0] rd1_reg;
    lvl_t                   lrd_reg;

    logic                   w_we;
    logic [AW-1:0]          w_addr;
    logic [WEIGHT_BITS-1:0] w_data;
    logic [AW-1:0]          r_addr0;
    logic [AW-1:0]          r_addr1;
    logic                   l_we;
    logic [AW-1:0]          l_waddr;
    lvl_t                   l_wdata;
    logic [AW-1:0]          l_raddr;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    stage_t                 stage_reg, stage_next;
    logic [LVL_W-1:0]       cur_k_reg, cur_k_next;
    logic [SUM_W-1:0]       cur_s_reg, cur_s_next;
    logic [SUM_W-1:0]       cur_r_reg, cur_r_next;
    logic [MAX_ITEMS-1:0]   mask_reg, mask_next;
    logic [LVL_W-1:0]       cnt_reg, cnt_next;
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic                   acc_v_reg, acc_v_next;
    logic [SUM_W-1:0]       a_reg, a_next;
    logic [SUM_W-1:0]       rest_reg, rest_next;
    logic [SUM_W-1:0]       b_reg, b_next;
    logic                   has_next_reg, has_next_next;
    logic                   found_reg, found_next;
    logic [sse_pkg::MASK_W-1:0] omask_reg, omask_next;
    logic                   exh_reg, exh_next;

    logic [LVL_W-1:0]       kp1;
    logic [SUM_W-1:0]       m_ext;
    logic [SUM_W-1:0]       w0_ext;
    logic [SUM_W-1:0]       w1_ext;
    logic [MAX_ITEMS-1:0]   bit_k;
    logic [MAX_ITEMS-1:0]   low_mask;
    logic [MAX_ITEMS-1:0]   mask_set;
    logic [WIDE_W-1:0]      wide_mask;

    assign kp1    = cur_k_reg + LVL_W'(1);
    assign m_ext  = SUM_W'(target_sum);
    assign w0_ext = SUM_W'(rd0_reg);
    assign w1_ext = SUM_W'(rd1_reg);
    assign bit_k  = MAX_ITEMS'(1) << cur_k_reg;
    assign mask_set = mask_reg | bit_k;

    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            low_mask[i] = (32'(cur_k_reg) >= i);
        end
    end

    assign wide_mask = WIDE_W'(mask_set & low_mask);

    assign ready          = (state_reg == S_IDLE);
    assign resp.valid     = (state_reg == S_RESP);
    assign resp.found     = found_reg;
    assign resp.mask      = omask_reg;
    assign resp.exhausted = exh_reg;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        stage_next    = stage_reg;
        cur_k_next    = cur_k_reg;
        cur_s_next    = cur_s_reg;
        cur_r_next    = cur_r_reg;
        mask_next     = mask_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        acc_v_next    = acc_v_reg;
        a_next        = a_reg;
        rest_next     = rest_reg;
        b_next        = b_reg;
        has_next_next = has_next_reg;
        found_next    = found_reg;
        omask_next    = omask_reg;
        exh_next      = exh_reg;

        w_we    = 1'b0;
        w_addr  = AW'(req.index);
        w_data  = WEIGHT_BITS'(req.weight);
        r_addr0 = cur_k_reg[AW-1:0];
        r_addr1 = kp1[AW-1:0];
        l_we    = 1'b0;
        l_waddr = cur_k_reg[AW-1:0];
        l_wdata = '{stage: ST_EXCL, psum: cur_s_reg, rsum: cur_r_reg};
        l_raddr = AW'(cur_k_reg - LVL_W'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    found_next = 1'b0;
                    omask_next = '0;
                    exh_next   = 1'b0;
                    state_next = S_RESP;
                    if (req.func == sse_pkg::FUNC_LOAD)
                    begin
                        w_we       = (32'(req.index) < MAX_ITEMS);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_RUN:
                            begin
                                state_next = S_READ;
                            end
                            PH_IDLE:
                            begin
                                if (active_count == '0)
                                begin
                                    phase_next = PH_DONE;
                                    exh_next   = 1'b1;
                                end
                                else
                                begin
                                    cnt_next   = '0;
                                    acc_next   = '0;
                                    acc_v_next = 1'b0;
                                    state_next = S_TOTAL;
                                end
                            end
                            default:
                            begin
                                exh_next = 1'b1;
                            end
                        endcase
                    end
                end
            end

            S_TOTAL:
            begin
                r_addr0 = cnt_reg[AW-1:0];
                if (acc_v_reg)
                begin
                    acc_next = acc_reg + w0_ext;
                end
                if (cnt_reg < active_count)
                begin
                    cnt_next   = cnt_reg + LVL_W'(1);
                    acc_v_next = 1'b1;
                end
                else
                begin
                    acc_v_next = 1'b0;
                    if (!acc_v_reg)
                    begin
                        cur_k_next = '0;
                        cur_s_next = '0;
                        cur_r_next = acc_reg;
                        stage_next = ST_INCL;
                        mask_next  = '0;
                        phase_next = PH_RUN;
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_ADD;
            end

            S_ADD:
            begin
                a_next        = cur_s_reg + w0_ext;
                rest_next     = (cur_r_reg >= w0_ext) ? (cur_r_reg - w0_ext) : '0;
                b_next        = cur_s_reg + w1_ext;
                has_next_next = (kp1 < active_count);
                state_next    = S_EVAL;
            end

            S_EVAL:
            begin
                case (stage_reg)
                    ST_INCL:
                    begin
                        stage_next = ST_EXCL;
                        mask_next  = mask_set;
                        if (a_reg == m_ext)
                        begin
                            found_next = 1'b1;
                            omask_next = wide_mask[sse_pkg::MASK_W-1:0];
                            exh_next   = 1'b0;
                            state_next = S_RESP;
                        end
                        else if (has_next_reg && (a_reg + w1_ext <= m_ext))
                        begin
                            l_we       = 1'b1;
                            l_wdata    = '{stage: ST_EXCL, psum: cur_s_reg, rsum: cur_r_reg};
                            cur_k_next = kp1;
                            cur_s_next = a_reg;
                            cur_r_next = rest_reg;
                            stage_next = ST_INCL;
                            state_next = S_READ;
                        end
                    end
                    ST_EXCL:
                    begin
                        stage_next = ST_POP;
                        if (has_next_reg && (cur_s_reg + rest_reg >= m_ext) && (b_reg <= m_ext))
                        begin
                            mask_next  = mask_reg & ~bit_k;
                            l_we       = 1'b1;
                            l_wdata    = '{stage: ST_POP, psum: cur_s_reg, rsum: cur_r_reg};
                            cur_k_next = kp1;
                            cur_r_next = rest_reg;
                            stage_next = ST_INCL;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        if (cur_k_reg == '0)
                        begin
                            phase_next = PH_DONE;
                            found_next = 1'b0;
                            omask_next = '0;
                            exh_next   = 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                endcase
            end

            S_POP:
            begin
                cur_k_next = cur_k_reg - LVL_W'(1);
                cur_s_next = lrd_reg.psum;
                cur_r_next = lrd_reg.rsum;
                stage_next = lrd_reg.stage;
                state_next = S_READ;
            end

            S_RESP:
            begin
                if (resp_ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_clear)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_addr] <= w_data;
        end
        rd0_reg <= wmem[r_addr0];
        rd1_reg <= wmem[r_addr1];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            lmem[l_waddr] <= l_wdata;
        end
        lrd_reg <= lmem[l_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_IDLE;
            stage_reg    <= ST_INCL;
            cur_k_reg    <= '0;
            cur_s_reg    <= '0;
            cur_r_reg    <= '0;
            mask_reg     <= '0;
            cnt_reg      <= '0;
            acc_reg      <= '0;
            acc_v_reg    <= 1'b0;
            a_reg        <= '0;
            rest_reg     <= '0;
            b_reg        <= '0;
            has_next_reg <= 1'b0;
            found_reg    <= 1'b0;
            omask_reg    <= '0;
            exh_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            stage_reg    <= stage_next;
            cur_k_reg    <= cur_k_next;
            cur_s_reg    <= cur_s_next;
            cur_r_reg    <= cur_r_next;
            mask_reg     <= mask_next;
            cnt_reg      <= cnt_next;
            acc_reg      <= acc_next;
            acc_v_reg    <= acc_v_next;
            a_reg        <= a_next;
            rest_reg     <= rest_next;
            b_reg        <= b_next;
            has_next_reg <= has_next_next;
            found_reg    <= found_next;
            omask_reg    <= omask_next;
            exh_reg      <= exh_next;
        end
    end

endmodule

// ===== hw/rtl/subset_sum_enumerator_top.sv =====
// Top level of the sum-of-subsets search block: handshakes, registers, output stage.
// Input channel (in_valid/in_stall) takes one item per transfer: func = load writes
// weight at index and restarts the search; func = next resumes the depth-first walk.
// Each item gives exactly one result on the output channel (out_valid/out_stall):
// found with subset_mask, or exhausted; a load returns all zeros.
// Configuration: cfg_we with cfg_index 0 (target_sum) or 1 (item_count); any write
// restarts the search. Write only while no item is in flight.
// Flow: a load, or a next that finds the search exhausted, goes from the transfer
// to S_RESP and on into the output register once that is free; the input then
// takes the next item. The first next after a restart first sums the active
// weights. Entering a level passes S_READ, S_ADD and S_EVAL up to its include
// decision on the adder and compare path, each later decision at that level
// another S_EVAL, each return to a lower level S_POP, S_READ, S_ADD and S_EVAL;
// the result then goes to S_RESP, so the total depends on weights and target.
// One item is in work at a time; in_stall stays high from the transfer until the
// result moves to the output register, which frees the engine for the next item
// while that result still waits on out_stall.
// Reset clears the registers, the output stage and the search; the weight store
// holds no value until loaded.
`timescale 1ns / 1ps

module subset_sum_enumerator_top #(
    parameter int MAX_ITEMS   = sse_pkg::MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = sse_pkg::WEIGHT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [sse_pkg::INDEX_W-1:0]    index,
    input  logic [sse_pkg::WEIGHT_W-1:0]   weight,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [sse_pkg::MASK_W-1:0]     subset_mask,
    output logic                           exhausted
);

    localparam int LVL_W = $clog2(MAX_ITEMS + 1);

    logic [sse_pkg::TARGET_W-1:0] target_sum_reg;
    logic [sse_pkg::COUNT_W-1:0]  item_count_reg;
    logic [LVL_W-1:0]             active_count;

    sse_pkg::req_t  req;
    sse_pkg::resp_t resp;
    logic           core_ready;
    logic           resp_ack;

    logic                       out_valid_reg;
    logic                       found_reg;
    logic [sse_pkg::MASK_W-1:0] mask_reg;
    logic                       exh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum_reg <= '0;
            item_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sse_pkg::CFG_TARGET_SUM:
                begin
                    target_sum_reg <= cfg_data[sse_pkg::TARGET_W-1:0];
                end
                sse_pkg::CFG_ITEM_COUNT:
                begin
                    item_count_reg <= cfg_data[sse_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    target_sum_reg <= target_sum_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (32'(item_count_reg) > MAX_ITEMS)
        begin
            active_count = LVL_W'(MAX_ITEMS);
        end
        else
        begin
            active_count = LVL_W'(item_count_reg);
        end
    end

    assign in_stall   = !core_ready;
    assign req.valid  = in_valid && core_ready;
    assign req.func   = func;
    assign req.index  = index;
    assign req.weight = weight;

    sse_core #(
        .MAX_ITEMS   (MAX_ITEMS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_clear    (cfg_we),
        .target_sum   (target_sum_reg),
        .active_count (active_count),
        .req          (req),
        .ready        (core_ready),
        .resp         (resp),
        .resp_ack     (resp_ack)
    );

    assign resp_ack = resp.valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            mask_reg      <= '0;
            exh_reg       <= 1'b0;
        end
        else if (resp_ack)
        begin
            out_valid_reg <= 1'b1;
            found_reg     <= resp.found;
            mask_reg      <= resp.mask;
            exh_reg       <= resp.exhausted;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign subset_mask = mask_reg;
    assign exhausted   = exh_reg;

endmodule

// ===== hw/rtl/sse_checker.sv =====
// Port-level checks for the sum-of-subsets search block, bound to the top level.
`timescale 1ns / 1ps

module sse_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       found,
    input logic [sse_pkg::MASK_W-1:0] subset_mask,
    input logic                       exhausted
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(found) && $stable(subset_mask) && $stable(exhausted))
        else $error("stalled output payload changed");

    // one item in work at a time
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while previous item still in work");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && exhausted))
        else $error("found and exhausted both set");

    a_mask_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> subset_mask == '0)
        else $error("subset_mask set without a match");

endmodule

bind subset_sum_enumerator_top sse_checker u_sse_checker (.*);

// ===== tb/tb.sv =====
// Testbench for subset_sum_enumerator_top: directed table, then predictor-checked runs.
`timescale 1ns / 1ps

module tb;

    localparam int     MASK_W       = sse_pkg::MASK_W;
    localparam int     INDEX_W      = sse_pkg::INDEX_W;
    localparam int     WEIGHT_W     = sse_pkg::WEIGHT_W;
    localparam int     CFG_IDX_W    = sse_pkg::CFG_IDX_W;
    localparam int     CFG_DATA_W   = sse_pkg::CFG_DATA_W;
    localparam int     TARGET_W     = sse_pkg::TARGET_W;
    localparam int     COUNT_W      = sse_pkg::COUNT_W;
    localparam int     N_ITEMS      = sse_pkg::MAX_ITEMS_DEF;
    localparam int     RANDOM_ITEMS = 520;
    localparam int     HOLD_CYCLES  = 400;
    localparam longint CYCLE_LIMIT  = 20000000;

    typedef enum logic [1:0] {WALK_IDLE, WALK_RUN, WALK_DONE} walk_phase_t;
    typedef enum logic [1:0] {STEP_TAKE, STEP_SKIP, STEP_BACK} node_step_t;
    typedef enum logic [1:0] {ROW_LOAD, ROW_FIND, ROW_REG} row_kind_t;

    typedef struct packed {
        logic              found;
        logic [MASK_W-1:0] mask;
        logic              exhausted;
    } subset_res_t;

    typedef struct {
        row_kind_t             kind;
        logic [INDEX_W-1:0]    idx;
        logic [WEIGHT_W-1:0]   wt;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        bit                    typed;
        subset_res_t           res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [INDEX_W-1:0]    index;
    logic [WEIGHT_W-1:0]   weight;
    logic                  out_valid;
    logic                  out_stall;
    logic                  found;
    logic [MASK_W-1:0]     subset_mask;
    logic                  exhausted;

    // predictor state
    logic [WEIGHT_W-1:0] wt_store [N_ITEMS];
    logic [MASK_W-1:0]   pick_mask;
    int unsigned         part_sum [N_ITEMS];
    int unsigned         rest_sum [N_ITEMS];
    node_step_t          node_step [N_ITEMS];
    int unsigned         depth;
    walk_phase_t         walk_phase;
    logic [TARGET_W-1:0] target_reg;
    logic [COUNT_W-1:0]  count_reg;

    subset_res_t expected_results [$];
    dir_row_t    dir_rows [$];

    int     idle_pct;
    int     stall_pct;
    bit     pressure_go;
    bit     hold_on;
    bit     last_exhausted;
    int     mismatches;
    int     items_done;
    int     results_seen;
    int     found_count;
    int     exhaust_count;
    int     reg_writes;
    int     search_runs;
    longint cycles;

    subset_sum_enumerator_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .index       (index),
        .weight      (weight),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .subset_mask (subset_mask),
        .exhausted   (exhausted)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void restart_walk();
        pick_mask = '0;
        for (int i = 0; i < N_ITEMS; i++)
        begin
            part_sum[i]  = 0;
            rest_sum[i]  = 0;
            node_step[i] = STEP_TAKE;
        end
        depth      = 0;
        walk_phase = WALK_IDLE;
    endfunction

    function automatic void open_level(int unsigned lvl, int unsigned s, int unsigned r);
        depth          = lvl;
        part_sum[lvl]  = s;
        rest_sum[lvl]  = r;
        node_step[lvl] = STEP_TAKE;
    endfunction

    function automatic subset_res_t find_next_subset();
        subset_res_t res;
        int unsigned n;
        int unsigned k;
        int unsigned s;
        int unsigned rs;
        int unsigned wk;
        int unsigned rest;
        int unsigned total;
        bit          has_next;
        res           = '0;
        res.exhausted = 1'b1;
        n = (count_reg > N_ITEMS) ? N_ITEMS : count_reg;
        if (walk_phase == WALK_DONE)
            return res;
        if (walk_phase == WALK_IDLE)
        begin
            if (n == 0)
            begin
                walk_phase = WALK_DONE;
                return res;
            end
            total = 0;
            for (int i = 0; i < n; i++)
                total += wt_store[i];
            pick_mask = '0;
            open_level(0, 0, total);
            walk_phase = WALK_RUN;
        end
        while (1)
        begin
            k = depth;
            if (k >= n)
            begin
                walk_phase = WALK_DONE;
                return res;
            end
            s        = part_sum[k];
            rs       = rest_sum[k];
            wk       = wt_store[k];
            rest     = (rs >= wk) ? rs - wk : 0;
            has_next = (k + 1 < n);
            if (node_step[k] == STEP_TAKE)
            begin
                node_step[k] = STEP_SKIP;
                pick_mask[k] = 1'b1;
                if (s + wk == target_reg)
                begin
                    res.found     = 1'b1;
                    res.exhausted = 1'b0;
                    res.mask      = pick_mask & MASK_W'((32'd1 << (k + 1)) - 1);
                    return res;
                end
                if (has_next && s + wk + wt_store[k + 1] <= target_reg)
                    open_level(k + 1, s + wk, rest);
            end
            else if (node_step[k] == STEP_SKIP)
            begin
                node_step[k] = STEP_BACK;
                if (has_next && s + rest >= target_reg && s + wt_store[k + 1] <= target_reg)
                begin
                    pick_mask[k] = 1'b0;
                    open_level(k + 1, s, rest);
                end
            end
            else
            begin
                if (k == 0)
                begin
                    walk_phase = WALK_DONE;
                    return res;
                end
                depth = k - 1;
            end
        end
    endfunction

    function automatic void add_load(logic [INDEX_W-1:0] idx, logic [WEIGHT_W-1:0] wt);
        dir_row_t row;
        row.kind    = ROW_LOAD;
        row.idx     = idx;
        row.wt      = wt;
        row.reg_sel = '0;
        row.reg_val = '0;
        row.typed   = 1'b1;
        row.res     = '0;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void add_find(bit typed, logic f, logic [MASK_W-1:0] m, logic e);
        dir_row_t row;
        row.kind          = ROW_FIND;
        row.idx           = INDEX_W'($urandom);
        row.wt            = WEIGHT_W'($urandom);
        row.reg_sel       = '0;
        row.reg_val       = '0;
        row.typed         = typed;
        row.res.found     = f;
        row.res.mask      = m;
        row.res.exhausted = e;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row.kind    = ROW_REG;
        row.idx     = '0;
        row.wt      = '0;
        row.reg_sel = sel;
        row.reg_val = val;
        row.typed   = 1'b0;
        row.res     = '0;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    task automatic offer_item(input logic fn, input logic [INDEX_W-1:0] idx,
                              input logic [WEIGHT_W-1:0] wt, input bit typed,
                              input subset_res_t typed_res);
        subset_res_t res;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        index    <= idx;
        weight   <= wt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (fn == sse_pkg::FUNC_LOAD)
        begin
            wt_store[idx] = wt;
            restart_walk();
            res = '0;
        end
        else
        begin
            res = find_next_subset();
        end
        last_exhausted = res.exhausted;
        if (res.found)
            found_count++;
        if (res.exhausted)
            exhaust_count++;
        expected_results.insert(expected_results.size(), typed ? typed_res : res);
        items_done++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == sse_pkg::CFG_TARGET_SUM)
            target_reg = val[TARGET_W-1:0];
        else
            count_reg = val[COUNT_W-1:0];
        restart_walk();
        reg_writes++;
    endtask

    // long receiver hold, counted in cycles
    initial
    begin
        hold_on = 1'b0;
        wait (pressure_go);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // result side: check each transfer, drive stall
    initial
    begin
        subset_res_t exp_res;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: found=%0d subset_mask=%h exhausted=%0d",
                           found, subset_mask, exhausted);
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (found !== exp_res.found)
                    begin
                        $error("found: expected %0d, actual %0d", exp_res.found, found);
                        mismatches++;
                    end
                    if (subset_mask !== exp_res.mask)
                    begin
                        $error("subset_mask: expected %h, actual %h", exp_res.mask, subset_mask);
                        mismatches++;
                    end
                    if (exhausted !== exp_res.exhausted)
                    begin
                        $error("exhausted: expected %0d, actual %0d",
                               exp_res.exhausted, exhausted);
                        mismatches++;
                    end
                end
            end
            if (hold_on)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        int unsigned wq [$];
        int unsigned n;
        int unsigned raw_count;
        int unsigned wmax;
        int unsigned tgt;
        int unsigned sum_pick;
        int unsigned sum_all;
        int unsigned pick;
        int unsigned cap;
        int unsigned tries;
        int          rand_start;
        int          group;
        bit          big;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        func      <= sse_pkg::FUNC_LOAD;
        index     <= '0;
        weight    <= '0;
        idle_pct    = 0;
        stall_pct   = 0;
        pressure_go = 1'b0;
        mismatches  = 0;
        items_done  = 0;
        results_seen  = 0;
        found_count   = 0;
        exhaust_count = 0;
        reg_writes    = 0;
        search_runs   = 0;
        target_reg  = '0;
        count_reg   = '0;
        for (int i = 0; i < N_ITEMS; i++)
            wt_store[i] = '0;
        restart_walk();

        // empty search after reset, then a repeat once exhausted
        add_find(1'b1, 1'b0, 16'h0000, 1'b1);
        add_find(1'b1, 1'b0, 16'h0000, 1'b1);
        for (int i = 0; i < N_ITEMS; i++)
            add_load(INDEX_W'(i), 16'hFFFF);
        // all sixteen heaviest weights reach the target, then resume to the end
        add_reg(sse_pkg::CFG_TARGET_SUM, 20'd1048560);
        add_reg(sse_pkg::CFG_ITEM_COUNT, 20'd16);
        add_find(1'b1, 1'b1, 16'hFFFF, 1'b0);
        add_find(1'b0, 1'b0, 16'h0000, 1'b0);
        // saturated count, unreachable target
        add_reg(sse_pkg::CFG_ITEM_COUNT, 20'd31);
        add_reg(sse_pkg::CFG_TARGET_SUM, 20'hFFFFF);
        add_find(1'b1, 1'b0, 16'h0000, 1'b1);
        // zero target met by a zero weight at the root
        add_reg(sse_pkg::CFG_TARGET_SUM, 20'd0);
        add_reg(sse_pkg::CFG_ITEM_COUNT, 20'd1);
        add_load(4'd0, 16'h0000);
        add_find(1'b1, 1'b1, 16'h0001, 1'b0);
        // unsorted pair, root has no guard
        add_reg(sse_pkg::CFG_ITEM_COUNT, 20'd2);
        add_reg(sse_pkg::CFG_TARGET_SUM, 20'd5);
        add_load(4'd0, 16'd9);
        add_load(4'd1, 16'd5);
        add_find(1'b0, 1'b0, 16'h0000, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            case (dir_rows[r].kind)
                ROW_REG:
                    write_reg(dir_rows[r].reg_sel, dir_rows[r].reg_val);
                ROW_LOAD:
                    offer_item(sse_pkg::FUNC_LOAD, dir_rows[r].idx, dir_rows[r].wt,
                               dir_rows[r].typed, dir_rows[r].res);
                default:
                    offer_item(sse_pkg::FUNC_NEXT, dir_rows[r].idx, dir_rows[r].wt,
                               dir_rows[r].typed, dir_rows[r].res);
            endcase
        end

        rand_start = items_done;
        group      = 0;
        while (items_done - rand_start < RANDOM_ITEMS)
        begin
            case (group % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    idle_pct  = 17;
                    stall_pct = 17;
                end
            endcase
            big = ($urandom_range(0, 9) == 0);
            if (group == 2)
                big = 1'b0;
            n = big ? $urandom_range(9, 16) : $urandom_range(0, 8);
            if (group == 2)
                n = 8;
            raw_count = n;
            if (n == 16 && $urandom_range(0, 1) == 1)
                raw_count = $urandom_range(17, 31);
            case ($urandom_range(0, 3))
                0:       wmax = 15;
                1:       wmax = 255;
                2:       wmax = 4095;
                default: wmax = 65535;
            endcase
            wq.delete();
            for (int i = 0; i < n; i++)
                wq.insert(wq.size(), $urandom_range(0, wmax));
            if ($urandom_range(0, 7) != 0)
                wq.sort();
            pick     = $urandom_range(0, 65535);
            sum_pick = 0;
            sum_all  = 0;
            for (int i = 0; i < n; i++)
            begin
                sum_all += wq[i];
                if (pick[i])
                    sum_pick += wq[i];
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: tgt = sum_pick;
                6:                tgt = sum_all;
                7:                tgt = 0;
                8:                tgt = $urandom_range(0, 20'hFFFFF);
                default:          tgt = sum_pick + 1;
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(sse_pkg::CFG_TARGET_SUM, CFG_DATA_W'(tgt));
                write_reg(sse_pkg::CFG_ITEM_COUNT, CFG_DATA_W'(raw_count));
            end
            else
            begin
                write_reg(sse_pkg::CFG_ITEM_COUNT, CFG_DATA_W'(raw_count));
                write_reg(sse_pkg::CFG_TARGET_SUM, CFG_DATA_W'(tgt));
            end
            if (group == 2)
                pressure_go = 1'b1;
            for (int i = 0; i < n; i++)
                offer_item(sse_pkg::FUNC_LOAD, INDEX_W'(i), WEIGHT_W'(wq[i]), 1'b0, '0);
            cap   = big ? 4 : 14;
            tries = 0;
            do
            begin
                offer_item(sse_pkg::FUNC_NEXT, INDEX_W'($urandom), WEIGHT_W'($urandom),
                           1'b0, '0);
                tries++;
                if (!big && $urandom_range(0, 11) == 0)
                    offer_item(sse_pkg::FUNC_LOAD, INDEX_W'($urandom), WEIGHT_W'($urandom),
                               1'b0, '0);
            end
            while (tries < cap && !(last_exhausted && $urandom_range(0, 2) != 0));
            search_runs++;
            group++;
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        $display("Covered %0d transfers in, %0d results, %0d register writes, %0d search runs",
                 items_done, results_seen, reg_writes, search_runs);
        $display("Results held %0d subsets and %0d exhausted reports; %0d mismatches",
                 found_count, exhaust_count, mismatches);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
